[sv/pfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the partition fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

	localparam int NUM_SLOTS  = 64;
	localparam int SIZE_BITS  = 16;
	localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
	localparam int COUNT_BITS = $clog2(NUM_SLOTS + 1);
	localparam int POL_BITS   = 2;
	localparam int CFG_BITS   = 7;
	localparam int IDX_BITS   = 1;

	localparam logic [POL_BITS-1:0] POL_FIRST = 2'd0;
	localparam logic [POL_BITS-1:0] POL_BEST  = 2'd1;
	localparam logic [POL_BITS-1:0] POL_WORST = 2'd2;

	localparam logic [IDX_BITS-1:0] REG_FIT_POLICY      = 1'd0;
	localparam logic [IDX_BITS-1:0] REG_PARTITION_COUNT = 1'd1;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	typedef struct packed {
		logic                 mode;
		logic [5:0]           slot;
		logic [15:0]          amount;
	} cmd_t;

	typedef struct packed {
		logic                 granted;
		logic [5:0]           chosen_slot;
		logic [15:0]          left_over;
	} result_t;

	typedef struct packed {
		logic                 en;
		logic [SLOT_BITS-1:0] addr;
		logic [SIZE_BITS-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic                 en;
		logic [SLOT_BITS-1:0] addr;
	} mem_rd_t;

endpackage

`default_nettype wire

[sv/pfa_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_table
// Free size table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_table (
	input  wire                          clk,
	input  pfa_pkg::mem_wr_t             wr,
	input  pfa_pkg::mem_rd_t             rd,
	output logic [pfa_pkg::SIZE_BITS-1:0] rd_data
);

	logic [pfa_pkg::SIZE_BITS-1:0] mem [pfa_pkg::NUM_SLOTS];
	logic [pfa_pkg::SIZE_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[sv/pfa_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_scan
// Sequencer and shared subtract/compare unit that walks the slots in use.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_scan (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  pfa_pkg::cmd_t                  cmd,
	input  wire [pfa_pkg::POL_BITS-1:0]    fit_policy,
	input  wire [pfa_pkg::COUNT_BITS-1:0]  partition_count,
	input  wire [pfa_pkg::SIZE_BITS-1:0]   rd_data,
	output pfa_pkg::mem_wr_t               wr,
	output pfa_pkg::mem_rd_t               rd,
	output logic                           busy,
	output logic                           done,
	output pfa_pkg::result_t               result
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]                      state_q;
	logic [pfa_pkg::COUNT_BITS-1:0]  idx_q;
	logic [pfa_pkg::COUNT_BITS-1:0]  n_q;
	logic                            cmp_vld_q;
	logic [pfa_pkg::SLOT_BITS-1:0]   cmp_idx_q;
	logic [pfa_pkg::SIZE_BITS-1:0]   req_q;
	logic                            found_q;
	logic [pfa_pkg::SLOT_BITS-1:0]   best_idx_q;
	logic [pfa_pkg::SIZE_BITS-1:0]   best_diff_q;
	logic                            done_q;
	pfa_pkg::result_t                result_q;

	logic [pfa_pkg::COUNT_BITS-1:0]  n_clamp;
	logic [pfa_pkg::SIZE_BITS:0]     sub;
	logic [pfa_pkg::SIZE_BITS-1:0]   diff;
	logic                            fits;
	logic                            take;
	logic                            issue;
	logic                            go;

	assign go = start && (state_q == ST_IDLE);
	assign n_clamp = (partition_count > pfa_pkg::COUNT_BITS'(pfa_pkg::NUM_SLOTS)) ?
		pfa_pkg::COUNT_BITS'(pfa_pkg::NUM_SLOTS) : partition_count;

	assign sub  = {1'b0, rd_data} - {1'b0, req_q};
	assign fits = !sub[pfa_pkg::SIZE_BITS];
	assign diff = sub[pfa_pkg::SIZE_BITS-1:0];

	always_comb begin
		take = 1'b0;
		if (cmp_vld_q && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_policy == pfa_pkg::POL_BEST) begin
				take = diff < best_diff_q;
			end else if (fit_policy == pfa_pkg::POL_WORST) begin
				take = diff > best_diff_q;
			end
		end
	end

	assign issue   = (state_q == ST_SCAN) && (idx_q != n_q);
	assign rd.en   = issue;
	assign rd.addr = idx_q[pfa_pkg::SLOT_BITS-1:0];

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = cmd.slot[pfa_pkg::SLOT_BITS-1:0];
		wr.data = cmd.amount[pfa_pkg::SIZE_BITS-1:0];
		if (go && cmd.mode == pfa_pkg::MODE_LOAD) begin
			wr.en = 1'b1;
		end else if (state_q == ST_FINISH && found_q) begin
			wr.en   = 1'b1;
			wr.addr = best_idx_q;
			wr.data = best_diff_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			n_q       <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go && cmd.mode == pfa_pkg::MODE_ALLOC) begin
						idx_q     <= '0;
						n_q       <= n_clamp;
						cmp_vld_q <= 1'b0;
						found_q   <= 1'b0;
						state_q   <= (n_clamp == '0) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= issue;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (!issue && cmp_vld_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			req_q <= cmd.amount[pfa_pkg::SIZE_BITS-1:0];
		end
		if (issue) begin
			cmp_idx_q <= idx_q[pfa_pkg::SLOT_BITS-1:0];
		end
		if (take) begin
			best_idx_q  <= cmp_idx_q;
			best_diff_q <= diff;
		end
		if (state_q == ST_FINISH) begin
			result_q.granted     <= found_q;
			result_q.chosen_slot <= found_q ? 6'(best_idx_q) : '0;
			result_q.left_over   <= found_q ? 16'(best_diff_q) : '0;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

[sv/partition_fit_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_fit_allocator
// First, best or worst fit allocator over a table of partition free sizes.
// ----------------------------------------------------------------------------
// Load word: written in the accept cycle, busy stays low, no result.
// Allocate word: result strobe after a scan of n = min(count, 64) slots;
//   busy until the strobe, one table read per cycle through a single compare.
// Zero slots in use: failure result without a table read.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset clears control and config registers; size table undefined until loaded.
`default_nettype none

module partition_fit_allocator (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  pfa_pkg::cmd_t                cmd,
	output logic                         busy,
	output logic                         done,
	output pfa_pkg::result_t             result,
	input  wire                          cfg_we,
	input  wire [pfa_pkg::IDX_BITS-1:0]  cfg_index,
	input  wire [pfa_pkg::CFG_BITS-1:0]  cfg_data
);

	logic [pfa_pkg::POL_BITS-1:0]   policy_q;
	logic [pfa_pkg::COUNT_BITS-1:0] count_q;
	logic [pfa_pkg::SIZE_BITS-1:0]  rd_data;
	pfa_pkg::mem_wr_t               wr;
	pfa_pkg::mem_rd_t               rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pfa_pkg::POL_FIRST;
			count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfa_pkg::REG_FIT_POLICY:      policy_q <= cfg_data[pfa_pkg::POL_BITS-1:0];
				pfa_pkg::REG_PARTITION_COUNT: count_q  <= cfg_data[pfa_pkg::COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	pfa_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	pfa_scan u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.cmd             (cmd),
		.fit_policy      (policy_q),
		.partition_count (count_q),
		.rd_data         (rd_data),
		.wr              (wr),
		.rd              (rd),
		.busy            (busy),
		.done            (done),
		.result          (result)
	);

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.granted |-> result.chosen_slot == '0 && result.left_over == '0)
		else $error("failed allocation carries nonzero fields");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && cmd.mode == pfa_pkg::MODE_ALLOC))
		else $error("busy without an allocate word");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of a scan");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.mode == pfa_pkg::MODE_LOAD |=> !busy)
		else $error("load word made the block busy");

endmodule

`default_nettype wire
